// ===== design/spc_pkg.sv =====
package spc_pkg;

    // defaults for the top-level size parameters
    localparam int DEF_MAX_IN_CH  = 8;
    localparam int DEF_MAX_OUT_CH = 8;
    localparam int DEF_MAX_TAPS   = 8;
    localparam int DEF_MAX_LEN    = 4096;

    // internal widths, sized for the largest supported parameter values
    localparam int CHW = 7;   // channel count, up to 64
    localparam int CIW = 6;   // channel index
    localparam int KW  = 6;   // tap count, up to 32
    localparam int TIW = 5;   // tap index / ring time bits
    localparam int TW  = 17;  // time positions, up to 65536 plus padding

    // result budget per input beat
    localparam int MAX_RESULTS = 64;
    localparam int BW          = 7;

    // job queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // register indexes
    localparam logic [2:0] REG_IN_CH   = 3'd0;
    localparam logic [2:0] REG_OUT_CH  = 3'd1;
    localparam logic [2:0] REG_KLEN    = 3'd2;
    localparam logic [2:0] REG_STRIDE  = 3'd3;
    localparam logic [2:0] REG_PADDING = 3'd4;
    localparam logic [2:0] REG_IN_LEN  = 3'd5;
    localparam logic [2:0] REG_BIAS_EN = 3'd6;

    // request codes
    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        JOB_WGT,
        JOB_BIAS,
        JOB_WIN,
        JOB_POS
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [8:0]       slot;
        logic [15:0]      value;
        logic [TIW-1:0]   win_t;
        logic [CIW-1:0]   win_c;
        logic [TW-1:0]    pos;
        logic             last;
    } job_t;

    // effective (clamped) configuration
    typedef struct packed {
        logic [CHW-1:0] cin;
        logic [CHW-1:0] cout;
        logic [KW-1:0]  k;
        logic [3:0]     s;
        logic [2:0]     p;
        logic [TW-1:0]  len;
        logic           bias_en;
    } cfg_t;

    typedef enum logic {
        F_IDLE,
        F_SCAN
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_MAC,
        B_DRAIN,
        B_OUT
    } back_state_t;

endpackage

// ===== design/spc_queue.sv =====
module spc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spc_pkg::job_t push_data,
    input  logic          pop,
    output spc_pkg::job_t pop_data,
    output logic          full,
    output logic          empty
);

    spc_pkg::job_t                  mem_reg [spc_pkg::QDEPTH];
    logic [spc_pkg::QAW-1:0]        wr_reg;
    logic [spc_pkg::QAW-1:0]        wr_next;
    logic [spc_pkg::QAW-1:0]        rd_reg;
    logic [spc_pkg::QAW-1:0]        rd_next;
    logic [spc_pkg::QAW:0]          cnt_reg;
    logic [spc_pkg::QAW:0]          cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign full     = (cnt_reg == (spc_pkg::QAW+1)'(spc_pkg::QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== design/spc_front.sv =====
module spc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spc_pkg::cfg_t        cfg,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           req_type,
    input  logic [8:0]           slot,
    input  logic signed [15:0]   value,
    input  logic                 q_full,
    output logic                 q_push,
    output spc_pkg::job_t        q_data
);

    localparam int MW = spc_pkg::TW + 5;

    spc_pkg::front_state_t      state_reg;
    spc_pkg::front_state_t      state_next;
    logic [spc_pkg::TW-1:0]     tcnt_reg;
    logic [spc_pkg::TW-1:0]     tcnt_next;
    logic [spc_pkg::CIW-1:0]    ccnt_reg;
    logic [spc_pkg::CIW-1:0]    ccnt_next;
    logic [spc_pkg::TW-1:0]     nxt_reg;
    logic [spc_pkg::TW-1:0]     nxt_next;
    logic [spc_pkg::BW-1:0]     budget_reg;
    logic [spc_pkg::BW-1:0]     budget_next;

    logic                       accept;
    logic                       complete;
    logic [MW-1:0]              os0;
    logic [MW-1:0]              end0;
    logic [MW-1:0]              end1;
    logic [MW-1:0]              lim_seq;
    logic [MW-1:0]              lim_seen;
    logic                       inrange0;
    logic                       rdy0;
    logic                       rdy1;
    logic [spc_pkg::BW-1:0]     budget_left;
    logic                       go;
    logic                       drained;
    logic                       keep;
    logic [spc_pkg::TW-1:0]     t0;
    logic [spc_pkg::CIW-1:0]    c0;
    logic [spc_pkg::CHW-1:0]    c_inc;

    assign req_stall = (state_reg != spc_pkg::F_IDLE) || q_full;
    assign accept    = req_valid && !req_stall;

    // readiness of the next two output positions
    always_comb
    begin
        complete    = (tcnt_reg >= cfg.len);
        os0         = MW'(nxt_reg) * MW'(cfg.s);
        end0        = os0 + MW'(cfg.k);
        end1        = end0 + MW'(cfg.s);
        lim_seq     = MW'(cfg.len) + MW'({cfg.p, 1'b0});
        lim_seen    = MW'(tcnt_reg) + MW'(cfg.p);
        inrange0    = (end0 <= lim_seq);
        rdy0        = inrange0 && (complete || end0 <= lim_seen);
        rdy1        = (end1 <= lim_seq) && (complete || end1 <= lim_seen);
        budget_left = budget_reg - spc_pkg::BW'(cfg.cout);
        go          = rdy0 && (budget_reg >= spc_pkg::BW'(cfg.cout));
    end

    // sample bookkeeping on an accepted beat
    always_comb
    begin
        drained = complete && !inrange0;
        keep    = !complete || drained;
        t0      = drained ? '0 : tcnt_reg;
        c0      = drained ? '0 : ccnt_reg;
        c_inc   = spc_pkg::CHW'(c0) + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spc_pkg::F_IDLE:
            begin
                if (accept && req_type == spc_pkg::REQ_SAMPLE)
                begin
                    state_next = spc_pkg::F_SCAN;
                end
            end
            spc_pkg::F_SCAN:
            begin
                if (!go)
                begin
                    state_next = spc_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = spc_pkg::F_IDLE;
            end
        endcase
    end

    // outputs and counter updates
    always_comb
    begin
        q_push       = 1'b0;
        q_data       = '0;
        q_data.slot  = slot;
        q_data.value = value;
        tcnt_next    = tcnt_reg;
        ccnt_next    = ccnt_reg;
        nxt_next     = nxt_reg;
        budget_next  = budget_reg;
        unique case (state_reg)
            spc_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        spc_pkg::REQ_WEIGHT:
                        begin
                            q_push      = 1'b1;
                            q_data.kind = spc_pkg::JOB_WGT;
                        end
                        spc_pkg::REQ_BIAS:
                        begin
                            q_push      = 1'b1;
                            q_data.kind = spc_pkg::JOB_BIAS;
                        end
                        spc_pkg::REQ_SAMPLE:
                        begin
                            budget_next = spc_pkg::BW'(spc_pkg::MAX_RESULTS);
                            if (keep)
                            begin
                                q_push       = 1'b1;
                                q_data.kind  = spc_pkg::JOB_WIN;
                                q_data.win_t = t0[spc_pkg::TIW-1:0];
                                q_data.win_c = c0;
                                nxt_next     = drained ? '0 : nxt_reg;
                                if (c_inc >= cfg.cin)
                                begin
                                    ccnt_next = '0;
                                    tcnt_next = t0 + 1'b1;
                                end
                                else
                                begin
                                    ccnt_next = c_inc[spc_pkg::CIW-1:0];
                                    tcnt_next = t0;
                                end
                            end
                        end
                        default:
                        begin
                            q_push = 1'b0;
                        end
                    endcase
                end
            end
            spc_pkg::F_SCAN:
            begin
                if (go && !q_full)
                begin
                    q_push      = 1'b1;
                    q_data.kind = spc_pkg::JOB_POS;
                    q_data.pos  = nxt_reg;
                    q_data.last = !(rdy1 && budget_left >= spc_pkg::BW'(cfg.cout));
                    nxt_next    = nxt_reg + 1'b1;
                    budget_next = budget_left;
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= spc_pkg::F_IDLE;
            tcnt_reg   <= '0;
            ccnt_reg   <= '0;
            nxt_reg    <= '0;
            budget_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tcnt_reg   <= tcnt_next;
            ccnt_reg   <= ccnt_next;
            nxt_reg    <= nxt_next;
            budget_reg <= budget_next;
        end
    end

endmodule

// ===== design/spc_back.sv =====
module spc_back #(
    parameter int MAX_IN_CH  = spc_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH = spc_pkg::DEF_MAX_OUT_CH,
    parameter int MAX_TAPS   = spc_pkg::DEF_MAX_TAPS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spc_pkg::cfg_t        cfg,
    input  logic                 q_empty,
    input  spc_pkg::job_t        q_data,
    output logic                 q_pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [2:0]           out_channel,
    output logic [12:0]          out_time,
    output logic signed [15:0]   out_value,
    output logic                 saturated,
    output logic                 last_of_run
);

    localparam int WDEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int RB     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CB     = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
    localparam int WINW   = RB + CB;
    localparam int BAW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int SW     = spc_pkg::TW + 6;

    logic [15:0]                wmem [WDEPTH];
    logic [15:0]                xmem [2**WINW];
    logic [15:0]                bmem [MAX_OUT_CH];

    spc_pkg::back_state_t       state_reg;
    spc_pkg::back_state_t       state_next;
    logic [WAW-1:0]             waddr_reg;
    logic [spc_pkg::TIW-1:0]    tap_reg;
    logic [spc_pkg::CIW-1:0]    ic_reg;
    logic [spc_pkg::CIW-1:0]    oc_reg;
    logic [spc_pkg::TW-1:0]     pos_reg;
    logic                       last_reg;
    logic signed [SW-1:0]       start_reg;
    logic                       dcnt_reg;

    logic [15:0]                w_rd_reg;
    logic [15:0]                x_rd_reg;
    logic [15:0]                b_rd_reg;
    logic                       ok1_reg;
    logic signed [31:0]         prod_reg;
    logic                       pv_reg;
    logic signed [39:0]         acc_reg;
    logic signed [39:0]         acc_next;

    logic                       out_valid_reg;
    logic [2:0]                 oc_out_reg;
    logic [12:0]                time_out_reg;
    logic signed [15:0]         value_out_reg;
    logic                       sat_out_reg;
    logic                       last_out_reg;

    logic                       pop_pos;
    logic                       last_issue;
    logic                       last_oc;
    logic                       out_free;
    logic                       out_load;
    logic [SW-4:0]              pos_s;
    logic signed [SW-1:0]       t_s;
    logic                       tap_ok;
    logic [WINW-1:0]            x_raddr;
    logic signed [39:0]         rsum;
    logic signed [25:0]         rshift;
    logic                       sat_hi;
    logic                       sat_lo;
    logic signed [15:0]         rval;

    assign q_pop      = (state_reg == spc_pkg::B_IDLE) && !q_empty;
    assign pop_pos    = q_pop && (q_data.kind == spc_pkg::JOB_POS);
    assign last_issue = (spc_pkg::CHW'(ic_reg) == cfg.cin - 1'b1) &&
                        (spc_pkg::KW'(tap_reg) == cfg.k - 1'b1);
    assign last_oc    = (spc_pkg::CHW'(oc_reg) == cfg.cout - 1'b1);
    assign out_free   = !out_valid_reg || !res_stall;
    assign out_load   = (state_reg == spc_pkg::B_OUT) && out_free;

    // input time of the current tap and its window address
    always_comb
    begin
        pos_s   = (SW-3)'(q_data.pos) * (SW-3)'(cfg.s);
        t_s     = start_reg + SW'(tap_reg);
        tap_ok  = !t_s[SW-1] && (t_s < $signed(SW'(cfg.len)));
        x_raddr = {t_s[RB-1:0], ic_reg[CB-1:0]};
    end

    // round half up and clip to q4.12
    always_comb
    begin
        rsum   = acc_reg + 40'sd8192;
        rshift = rsum[39:14];
        sat_hi = (rshift > 26'sd32767);
        sat_lo = (rshift < -26'sd32768);
        if (sat_hi)
        begin
            rval = 16'sh7fff;
        end
        else if (sat_lo)
        begin
            rval = -16'sh8000;
        end
        else
        begin
            rval = rshift[15:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spc_pkg::B_IDLE:
            begin
                if (pop_pos)
                begin
                    state_next = spc_pkg::B_START;
                end
            end
            spc_pkg::B_START:
            begin
                state_next = spc_pkg::B_MAC;
            end
            spc_pkg::B_MAC:
            begin
                if (last_issue)
                begin
                    state_next = spc_pkg::B_DRAIN;
                end
            end
            spc_pkg::B_DRAIN:
            begin
                if (dcnt_reg)
                begin
                    state_next = spc_pkg::B_OUT;
                end
            end
            spc_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    state_next = last_oc ? spc_pkg::B_IDLE : spc_pkg::B_START;
                end
            end
            default:
            begin
                state_next = spc_pkg::B_IDLE;
            end
        endcase
    end

    // accumulator: bias start on the first mac cycle, then add products
    always_comb
    begin
        acc_next = acc_reg;
        if (state_reg == spc_pkg::B_MAC && state_next != state_reg && 1'b0)
        begin
            acc_next = acc_reg;
        end
        if (pv_reg)
        begin
            acc_next = acc_reg + 40'(prod_reg);
        end
        if (state_reg == spc_pkg::B_START)
        begin
            acc_next = '0;
        end
    end

    // sequencer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spc_pkg::B_IDLE;
            waddr_reg <= '0;
            tap_reg   <= '0;
            ic_reg    <= '0;
            oc_reg    <= '0;
            dcnt_reg  <= 1'b0;
            ok1_reg   <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok1_reg   <= (state_reg == spc_pkg::B_MAC) && tap_ok;
            pv_reg    <= ok1_reg;
            dcnt_reg  <= (state_reg == spc_pkg::B_DRAIN) && !dcnt_reg;
            if (pop_pos)
            begin
                waddr_reg <= '0;
                oc_reg    <= '0;
            end
            if (state_reg == spc_pkg::B_START)
            begin
                tap_reg <= '0;
                ic_reg  <= '0;
            end
            if (state_reg == spc_pkg::B_MAC)
            begin
                waddr_reg <= waddr_reg + 1'b1;
                if (spc_pkg::KW'(tap_reg) == cfg.k - 1'b1)
                begin
                    tap_reg <= '0;
                    ic_reg  <= ic_reg + 1'b1;
                end
                else
                begin
                    tap_reg <= tap_reg + 1'b1;
                end
            end
            if (out_load && !last_oc)
            begin
                oc_reg <= oc_reg + 1'b1;
            end
        end
    end

    // job fields and mac datapath
    always_ff @(posedge clk)
    begin
        if (pop_pos)
        begin
            pos_reg   <= q_data.pos;
            last_reg  <= q_data.last;
            start_reg <= $signed({3'b000, pos_s}) - $signed(SW'(cfg.p));
        end
        prod_reg <= $signed(w_rd_reg) * $signed(x_rd_reg);
        if (state_reg == spc_pkg::B_MAC && tap_reg == '0 && ic_reg == '0)
        begin
            acc_reg <= (cfg.bias_en ? {{10{b_rd_reg[15]}}, b_rd_reg, 14'b0} : 40'sd0)
                       + (pv_reg ? 40'(prod_reg) : 40'sd0);
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.kind == spc_pkg::JOB_WGT && int'(q_data.slot) < WDEPTH)
        begin
            wmem[WAW'(q_data.slot)] <= q_data.value;
        end
        w_rd_reg <= wmem[waddr_reg];
    end

    // sample window
    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.kind == spc_pkg::JOB_WIN)
        begin
            xmem[{q_data.win_t[RB-1:0], q_data.win_c[CB-1:0]}] <= q_data.value;
        end
        x_rd_reg <= xmem[x_raddr];
    end

    // bias store
    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.kind == spc_pkg::JOB_BIAS && int'(q_data.slot) < MAX_OUT_CH)
        begin
            bmem[BAW'(q_data.slot)] <= q_data.value;
        end
        b_rd_reg <= bmem[oc_reg[BAW-1:0]];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            oc_out_reg    <= oc_reg[2:0];
            time_out_reg  <= pos_reg[12:0];
            value_out_reg <= rval;
            sat_out_reg   <= sat_hi || sat_lo;
            last_out_reg  <= last_reg && last_oc;
        end
    end

    assign res_valid   = out_valid_reg;
    assign out_channel = oc_out_reg;
    assign out_time    = time_out_reg;
    assign out_value   = value_out_reg;
    assign saturated   = sat_out_reg;
    assign last_of_run = last_out_reg;

endmodule

// ===== design/strided_padded_conv1d.sv =====
// a sample beat passes through the front end and the job queue to the back end, where
// each result is computed on the single multiply-accumulate unit; a sample beat that
// completes one position keeps the back end busy until all cout results are out
// reset clears counters, queue and handshakes; weight, bias and window stores
// hold garbage until written, registers return to their defaults
module strided_padded_conv1d #(
    parameter int MAX_IN_CH  = spc_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH = spc_pkg::DEF_MAX_OUT_CH,
    parameter int MAX_TAPS   = spc_pkg::DEF_MAX_TAPS,
    parameter int MAX_LEN    = spc_pkg::DEF_MAX_LEN
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           req_type,
    input  logic [8:0]           slot,
    input  logic signed [15:0]   value,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [2:0]           out_channel,
    output logic [12:0]          out_time,
    output logic signed [15:0]   out_value,
    output logic                 saturated,
    output logic                 last_of_run
);

    logic [3:0]         in_ch_reg;
    logic [3:0]         out_ch_reg;
    logic [3:0]         klen_reg;
    logic [3:0]         stride_reg;
    logic [2:0]         pad_reg;
    logic [12:0]        len_reg;
    logic               bias_en_reg;
    logic               wr_en;
    logic [2:0]         ridx;
    spc_pkg::cfg_t      cfg;

    logic               q_push;
    spc_pkg::job_t      q_wdata;
    logic               q_pop;
    spc_pkg::job_t      q_rdata;
    logic               q_full;
    logic               q_empty;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = paddr[4:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg   <= 4'd1;
            out_ch_reg  <= 4'd1;
            klen_reg    <= 4'd3;
            stride_reg  <= 4'd2;
            pad_reg     <= 3'd1;
            len_reg     <= 13'd4096;
            bias_en_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (ridx)
                spc_pkg::REG_IN_CH:   in_ch_reg   <= pwdata[3:0];
                spc_pkg::REG_OUT_CH:  out_ch_reg  <= pwdata[3:0];
                spc_pkg::REG_KLEN:    klen_reg    <= pwdata[3:0];
                spc_pkg::REG_STRIDE:  stride_reg  <= pwdata[3:0];
                spc_pkg::REG_PADDING: pad_reg     <= pwdata[2:0];
                spc_pkg::REG_IN_LEN:  len_reg     <= pwdata[12:0];
                spc_pkg::REG_BIAS_EN: bias_en_reg <= pwdata[0];
                default:              bias_en_reg <= bias_en_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (ridx)
            spc_pkg::REG_IN_CH:   prdata = 32'(in_ch_reg);
            spc_pkg::REG_OUT_CH:  prdata = 32'(out_ch_reg);
            spc_pkg::REG_KLEN:    prdata = 32'(klen_reg);
            spc_pkg::REG_STRIDE:  prdata = 32'(stride_reg);
            spc_pkg::REG_PADDING: prdata = 32'(pad_reg);
            spc_pkg::REG_IN_LEN:  prdata = 32'(len_reg);
            spc_pkg::REG_BIAS_EN: prdata = 32'(bias_en_reg);
            default:              prdata = '0;
        endcase
    end

    // clamp registers to the supported ranges
    always_comb
    begin
        if (in_ch_reg == '0)
            cfg.cin = spc_pkg::CHW'(1);
        else if (int'(in_ch_reg) > MAX_IN_CH)
            cfg.cin = spc_pkg::CHW'(MAX_IN_CH);
        else
            cfg.cin = spc_pkg::CHW'(in_ch_reg);
        if (out_ch_reg == '0)
            cfg.cout = spc_pkg::CHW'(1);
        else if (int'(out_ch_reg) > MAX_OUT_CH)
            cfg.cout = spc_pkg::CHW'(MAX_OUT_CH);
        else
            cfg.cout = spc_pkg::CHW'(out_ch_reg);
        if (klen_reg == '0)
            cfg.k = spc_pkg::KW'(1);
        else if (int'(klen_reg) > MAX_TAPS)
            cfg.k = spc_pkg::KW'(MAX_TAPS);
        else
            cfg.k = spc_pkg::KW'(klen_reg);
        cfg.s = (stride_reg == '0) ? 4'd1 : stride_reg;
        cfg.p = pad_reg;
        if (len_reg == '0)
            cfg.len = spc_pkg::TW'(1);
        else if (int'(len_reg) > MAX_LEN)
            cfg.len = spc_pkg::TW'(MAX_LEN);
        else
            cfg.len = spc_pkg::TW'(len_reg);
        cfg.bias_en = bias_en_reg;
    end

    spc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .slot      (slot),
        .value     (value),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    spc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    spc_back #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_TAPS   (MAX_TAPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .out_channel (out_channel),
        .out_time    (out_time),
        .out_value   (out_value),
        .saturated   (saturated),
        .last_of_run (last_of_run)
    );

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    // result channel index stays below the output channel count
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (7'(out_channel) < cfg.cout || cfg.cout > 7'd8))
        else $error("output channel out of range");

    // end of run marks only the last output channel of a position
    a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && last_of_run) |-> (7'(out_channel) == cfg.cout - 7'd1 || cfg.cout > 7'd8))
        else $error("end of run on a middle channel");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int WDEPTH   = 512;
    localparam int WINDEPTH = 64;
    localparam int DRAIN_CYCLES = 600;
    localparam int STALL_LIMIT  = 20000;

    typedef struct {
        logic [1:0]  kind;
        logic [8:0]  slot;
        logic [15:0] value;
    } beat_t;

    typedef struct {
        logic [2:0]  ch;
        logic [12:0] tm;
        logic [15:0] val;
        logic        sat;
        logic        last;
    } conv_res_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_type;
    logic [8:0]  slot;
    logic signed [15:0] value;
    logic        res_valid;
    logic        res_stall;
    logic [2:0]  out_channel;
    logic [12:0] out_time;
    logic signed [15:0] out_value;
    logic        saturated;
    logic        last_of_run;

    strided_padded_conv1d DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
        .slot(slot), .value(value),
        .res_valid(res_valid), .res_stall(res_stall),
        .out_channel(out_channel), .out_time(out_time), .out_value(out_value),
        .saturated(saturated), .last_of_run(last_of_run)
    );

    // mirror of the block's state
    logic [3:0]  r_cin, r_cout, r_klen, r_stride;
    logic [2:0]  r_pad;
    logic [12:0] r_len;
    logic        r_bias_en;
    logic [15:0] weights [WDEPTH];
    logic [15:0] biases [8];
    logic [15:0] window [WINDEPTH];
    int          time_cnt;
    int          chan_cnt;
    int          next_pos;

    beat_t       pending_beats[$];
    conv_res_t   expected_res[$];
    beat_t       drv_beat;
    int          errors;
    bit          quiet;
    bit          req_taken;
    int          req_gap;
    int          stall_left;
    int          no_progress;

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int n_cin();
        return clip(r_cin, 1, 8);
    endfunction

    function automatic int n_cout();
        return clip(r_cout, 1, 8);
    endfunction

    function automatic int n_taps();
        return clip(r_klen, 1, 8);
    endfunction

    function automatic int n_stride();
        return r_stride == 0 ? 1 : r_stride;
    endfunction

    function automatic int n_len();
        return clip(r_len, 1, 4096);
    endfunction

    function automatic int n_positions();
        int span;
        span = n_len() + 2 * r_pad;
        if (span < n_taps())
            return 0;
        return (span - n_taps()) / n_stride() + 1;
    endfunction

    function automatic bit position_ready(int o);
        if (o >= n_positions())
            return 0;
        if (time_cnt >= n_len())
            return 1;
        return o * n_stride() - r_pad + n_taps() - 1 < time_cnt;
    endfunction

    function automatic bit sequence_done();
        return time_cnt >= n_len() && next_pos >= n_positions();
    endfunction

    // one output sample for position o, channel oc
    function automatic conv_res_t conv_point(int o, int oc);
        conv_res_t r;
        longint acc;
        longint q;
        int t;
        int start;
        start = o * n_stride() - r_pad;
        acc = r_bias_en ? longint'($signed(biases[oc])) * 16384 : 0;
        for (int tap = 0; tap < n_taps(); tap++) begin
            t = start + tap;
            if (t >= 0 && t < n_len()) begin
                for (int ic = 0; ic < n_cin(); ic++) begin
                    acc += longint'($signed(weights[((oc * n_cin() + ic) * n_taps() + tap)
                        % WDEPTH])) * longint'($signed(window[(t % 8) * 8 + ic]));
                end
            end
        end
        q = (acc + 8192) >>> 14;
        r.sat = 0;
        if (q > 32767) begin
            q = 32767;
            r.sat = 1;
        end
        if (q < -32768) begin
            q = -32768;
            r.sat = 1;
        end
        r.ch = oc[2:0];
        r.tm = o[12:0];
        r.val = q[15:0];
        r.last = 0;
        return r;
    endfunction

    // apply one accepted beat to the mirror and queue its results
    task automatic predict_conv(beat_t b);
        bit keep;
        int budget;
        int made;
        conv_res_t r;
        keep = 1;
        made = 0;
        case (b.kind)
            spc_pkg::REQ_WEIGHT: weights[b.slot] = b.value;
            spc_pkg::REQ_BIAS: if (b.slot < 8) biases[b.slot] = b.value;
            spc_pkg::REQ_SAMPLE:
            begin
                if (time_cnt >= n_len()) begin
                    if (next_pos >= n_positions()) begin
                        time_cnt = 0;
                        chan_cnt = 0;
                        next_pos = 0;
                    end else begin
                        keep = 0;
                    end
                end
                if (keep) begin
                    window[(time_cnt % 8) * 8 + chan_cnt % 8] = b.value;
                    chan_cnt++;
                    if (chan_cnt >= n_cin()) begin
                        chan_cnt = 0;
                        time_cnt++;
                    end
                end
                budget = 64 / n_cout();
                while (budget > 0 && position_ready(next_pos)) begin
                    for (int oc = 0; oc < n_cout(); oc++) begin
                        expected_res.push_back(conv_point(next_pos, oc));
                        made++;
                    end
                    next_pos++;
                    budget--;
                end
                if (made > 0) begin
                    r = expected_res.pop_back();
                    r.last = 1;
                    expected_res.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // request side: acceptance
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            predict_conv(drv_beat);
            req_taken <= 1'b1;
        end
    end

    // request side: drive the next beat
    always @(negedge clk)
    begin
        if (rst_n && (req_taken || !req_valid))
        begin
            req_taken <= 1'b0;
            if (req_gap > 0) begin
                req_valid <= 1'b0;
                req_gap--;
            end else if (pending_beats.size() > 0) begin
                drv_beat = pending_beats.pop_front();
                req_type <= drv_beat.kind;
                slot <= drv_beat.slot;
                value <= drv_beat.value;
                req_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    req_gap = $urandom_range(1, 4);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // result side: stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            res_stall <= 1'b1;
            stall_left--;
        end else begin
            res_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
        end
    end

    // result side: compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        conv_res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected result ch=%0d time=%0d value=%0d",
                         $time, out_channel, out_time, out_value);
                errors++;
            end else begin
                e = expected_res.pop_front();
                if (out_channel !== e.ch || out_time !== e.tm || out_value !== e.val
                    || saturated !== e.sat || last_of_run !== e.last) begin
                    $display("%0t: mismatch expected ch=%0d time=%0d value=%0d sat=%0b last=%0b",
                             $time, e.ch, e.tm, $signed(e.val), e.sat, e.last);
                    $display("%0t:          actual   ch=%0d time=%0d value=%0d sat=%0b last=%0b",
                             $time, out_channel, out_time, out_value, saturated, last_of_run);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without progress
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || (psel && penable))
            no_progress <= 0;
        else
            no_progress <= no_progress + 1;
        if (no_progress >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_beat(logic [1:0] kind, logic [8:0] sl, logic [15:0] v);
        beat_t b;
        b.kind = kind;
        b.slot = sl;
        b.value = v;
        pending_beats.push_back(b);
    endtask

    function automatic logic [15:0] rand_word();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($signed($urandom_range(0, 4095)) - 2048);
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            spc_pkg::REG_IN_CH:   r_cin = data[3:0];
            spc_pkg::REG_OUT_CH:  r_cout = data[3:0];
            spc_pkg::REG_KLEN:    r_klen = data[3:0];
            spc_pkg::REG_STRIDE:  r_stride = data[3:0];
            spc_pkg::REG_PADDING: r_pad = data[2:0];
            spc_pkg::REG_IN_LEN:  r_len = data[12:0];
            spc_pkg::REG_BIAS_EN: r_bias_en = data[0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_empty();
        do
            @(posedge clk);
        while (pending_beats.size() > 0 || req_valid || expected_res.size() > 0);
    endtask

    // feed samples until the current sequence is complete and drained
    task automatic complete_sequence();
        int need;
        forever
        begin
            wait_empty();
            if (sequence_done())
                break;
            need = time_cnt >= n_len() ? 1 : (n_len() - time_cnt) * n_cin() - chan_cnt;
            for (int i = 0; i < need; i++)
                push_beat(spc_pkg::REQ_SAMPLE, 9'($urandom_range(0, 511)), rand_word());
        end
    endtask

    task automatic run_phase(int cin, int cout, int klen, int strd, int pad, int len, int ben,
                             bit load);
        int n;
        int nw;
        repeat (DRAIN_CYCLES) @(posedge clk);
        reg_write(spc_pkg::REG_IN_CH, 32'(cin));
        reg_write(spc_pkg::REG_OUT_CH, 32'(cout));
        reg_write(spc_pkg::REG_KLEN, 32'(klen));
        reg_write(spc_pkg::REG_STRIDE, 32'(strd));
        reg_write(spc_pkg::REG_PADDING, 32'(pad));
        reg_write(spc_pkg::REG_IN_LEN, 32'(len));
        reg_write(spc_pkg::REG_BIAS_EN, 32'(ben));
        // weights and biases this shape reads, extremes first
        if (load) begin
            nw = n_cout() * n_cin() * n_taps();
            push_beat(spc_pkg::REQ_WEIGHT, 9'd0, 16'h7FFF);
            if (nw > 1)
                push_beat(spc_pkg::REQ_WEIGHT, 9'd1, 16'h8000);
            for (int i = 2; i < nw; i++)
                push_beat(spc_pkg::REQ_WEIGHT, 9'(i), rand_word());
            if (r_bias_en)
                for (int i = 0; i < n_cout(); i++)
                    push_beat(spc_pkg::REQ_BIAS, 9'(i), rand_word());
        end
        // one sequence of samples with loads and ignored beats mixed in
        n = n_len() * n_cin();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: push_beat(spc_pkg::REQ_WEIGHT, 9'($urandom_range(0, 511)), rand_word());
                    1: push_beat(spc_pkg::REQ_BIAS, 9'($urandom_range(0, 7)), rand_word());
                    2: push_beat(spc_pkg::REQ_BIAS, 9'($urandom_range(8, 511)), rand_word());
                    default: push_beat(2'd3, 9'($urandom_range(0, 511)),
                                       16'($urandom_range(0, 65535)));
                endcase
            end
            if (i == 0)
                push_beat(spc_pkg::REQ_SAMPLE, 9'd0, 16'h7FFF);
            else if (i == 1)
                push_beat(spc_pkg::REQ_SAMPLE, 9'd511, 16'h8000);
            else
                push_beat(spc_pkg::REQ_SAMPLE, 9'($urandom_range(0, 511)), rand_word());
        end
        complete_sequence();
    endtask

    initial
    begin
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        req_valid = 0;
        req_type = spc_pkg::REQ_SAMPLE;
        slot = 0;
        value = 0;
        res_stall = 0;
        req_taken = 0;
        req_gap = 0;
        stall_left = 0;
        no_progress = 0;
        errors = 0;
        quiet = 0;
        r_cin = 1;
        r_cout = 1;
        r_klen = 3;
        r_stride = 2;
        r_pad = 1;
        r_len = 4096;
        r_bias_en = 1;
        time_cnt = 0;
        chan_cnt = 0;
        next_pos = 0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // ignored beats right after reset
        push_beat(spc_pkg::REQ_BIAS, 9'd511, 16'hFFFF);
        push_beat(2'd3, 9'd511, 16'hFFFF);

        // each shape below starts once the previous sequence is drained
        run_phase(2, 3, 3, 1, 1, 6, 1, 1);
        // eight output channels, saturating extremes
        run_phase(1, 8, 2, 1, 0, 5, 1, 1);
        run_phase(4, 1, 3, 3, 2, 4, 0, 1);
        // too short for any position
        run_phase(1, 3, 8, 1, 0, 3, 1, 0);
        quiet = 1;
        // more ready positions than one beat may emit, drained by later samples
        run_phase(1, 8, 1, 1, 7, 1, 1, 0);
        // out-of-range register values clamp
        run_phase(0, 15, 0, 0, 0, 0, 1, 0);
        run_phase(2, 2, 3, 1, 1, 1, 1, 1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/spc_pkg.sv
design/spc_queue.sv
design/spc_front.sv
design/spc_back.sv
design/strided_padded_conv1d.sv
dv/tb.sv
